FILE: rtl/gta_pkg.sv
// shared constants and gf(2^128) helpers for the ghash tag accumulator
package gta_pkg;

  localparam int unsigned BlockW = 128;
  localparam int unsigned AadW   = 61;
  localparam int unsigned TextW  = 36;
  localparam int unsigned CountW = 5;

  localparam logic [1:0] CMD_AAD    = 2'd0;
  localparam logic [1:0] CMD_TEXT   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [CountW-1:0] FullCount = CountW'(16);

  localparam logic [AadW:0]  AadLimit  = {1'b0, {AadW{1'b1}}};
  localparam logic [TextW:0] TextLimit = (TextW+1)'((64'd1 << TextW) - 64'd32);

  typedef struct packed {
    logic [1:0]        cmd;
    logic [BlockW-1:0] data;
    logic [CountW-1:0] cnt;
    logic [BlockW-1:0] mask;
  } word_t;

  // keep the leading cnt bytes, byte 0 in the top bits
  function automatic logic [BlockW-1:0] byte_mask(logic [CountW-1:0] cnt);
    logic [BlockW-1:0] m;
    m = '0;
    for (int b = 0; b < 16; b++) begin
      if (CountW'(b) < cnt) begin
        m[BlockW-1-8*b -: 8] = 8'hff;
      end
    end
    return m;
  endfunction

  // reflected gf(2^128) product, reduction polynomial x^128 + x^7 + x^2 + x + 1
  function automatic logic [BlockW-1:0] gf128_mul(logic [BlockW-1:0] a,
                                                  logic [BlockW-1:0] b);
    logic [BlockW-1:0]   ar;
    logic [BlockW-1:0]   br;
    logic [2*BlockW-2:0] p;
    logic [BlockW-2:0]   u;
    logic [BlockW+5:0]   t;
    logic [5:0]          hi;
    logic [BlockW-1:0]   z;
    logic [BlockW-1:0]   zr;
    for (int i = 0; i < BlockW; i++) begin
      ar[i] = a[BlockW-1-i];
      br[i] = b[BlockW-1-i];
    end
    for (int j = 0; j < 2*BlockW-1; j++) begin
      p[j] = 1'b0;
      for (int i = 0; i < BlockW; i++) begin
        if ((j >= i) && (j - i < BlockW)) begin
          p[j] = p[j] ^ (ar[i] & br[j-i]);
        end
      end
    end
    u  = p[2*BlockW-2:BlockW];
    t  = {7'b0, u} ^ {6'b0, u, 1'b0} ^ {5'b0, u, 2'b0} ^ {u, 7'b0};
    hi = t[BlockW+5:BlockW];
    z  = p[BlockW-1:0] ^ t[BlockW-1:0] ^ {122'b0, hi} ^ {121'b0, hi, 1'b0}
         ^ {120'b0, hi, 2'b0} ^ {115'b0, hi, 7'b0};
    for (int i = 0; i < BlockW; i++) begin
      zr[i] = z[BlockW-1-i];
    end
    return zr;
  endfunction

endpackage

FILE: rtl/ghash_tag_accumulator.sv
// ghash tag accumulator: one gf(2^128) multiply per word, tag on finish
// a finish word is taken into the input word register, then its tag into the result register
// throughput: one word per cycle unless a finish waits; the accumulator loop closes through
// one gf(2^128) multiplier into acc_q; a finish waits only while a held tag is stalled
// reset clears the accumulator, byte totals, error flag, hash key and all valid bits
module ghash_tag_accumulator import gta_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [63:0]       data_high_i,
  input  logic [63:0]       data_low_i,
  input  logic [CountW-1:0] byte_count_i,
  input  logic [63:0]       mask_high_i,
  input  logic [63:0]       mask_low_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [63:0]       tag_high_o,
  output logic [63:0]       tag_low_o,
  output logic              length_error_o
);

  logic [BlockW-1:0] key_q;
  logic              wv_q;
  word_t             w_q, w_d;
  logic [BlockW-1:0] acc_q;
  logic [AadW-1:0]   aad_q;
  logic [TextW-1:0]  text_q;
  logic              err_q;
  logic              ov_q;
  logic [BlockW-1:0] tag_q, tag_d;
  logic              lerr_q;

  logic              accept;
  logic              useful;
  logic [CountW-1:0] cnt_sat;
  logic              is_finish;
  logic              go;
  logic [BlockW-1:0] x;
  logic [BlockW-1:0] prod;
  logic [AadW:0]     aad_sum;
  logic [TextW:0]    text_sum;

  // input word register
  assign cnt_sat = (byte_count_i > FullCount) ? FullCount : byte_count_i;
  assign useful  = ((command_i == CMD_AAD || command_i == CMD_TEXT) && byte_count_i != '0)
                   || (command_i == CMD_FINISH);
  assign accept  = in_valid_i && !in_stall_o;

  always_comb begin
    w_d.cmd  = command_i;
    w_d.data = {data_high_i, data_low_i} & byte_mask(cnt_sat);
    w_d.cnt  = cnt_sat;
    w_d.mask = {mask_high_i, mask_low_i};
  end

  // execute
  assign is_finish  = (w_q.cmd == CMD_FINISH);
  assign go         = wv_q && !(is_finish && ov_q && out_stall_i);
  assign in_stall_o = wv_q && !go;

  assign x        = is_finish ? {aad_q, 3'b0, 25'b0, text_q, 3'b0} : w_q.data;
  assign prod     = gf128_mul(acc_q ^ x, key_q);
  assign aad_sum  = {1'b0, aad_q} + (AadW+1)'(w_q.cnt);
  assign text_sum = {1'b0, text_q} + (TextW+1)'(w_q.cnt);
  assign tag_d    = prod ^ w_q.mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      wv_q   <= 1'b0;
      acc_q  <= '0;
      aad_q  <= '0;
      text_q <= '0;
      err_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i) begin
          key_q[63:0] <= cfg_data_i;
        end else begin
          key_q[BlockW-1:64] <= cfg_data_i;
        end
      end
      if (accept) begin
        wv_q <= useful;
      end else if (go) begin
        wv_q <= 1'b0;
      end
      if (go) begin
        case (w_q.cmd)
          CMD_AAD: begin
            acc_q <= prod;
            if (aad_sum > AadLimit) begin
              aad_q <= AadLimit[AadW-1:0];
              err_q <= 1'b1;
            end else begin
              aad_q <= aad_sum[AadW-1:0];
            end
          end
          CMD_TEXT: begin
            acc_q <= prod;
            if (text_sum > TextLimit) begin
              text_q <= TextLimit[TextW-1:0];
              err_q  <= 1'b1;
            end else begin
              text_q <= text_sum[TextW-1:0];
            end
          end
          CMD_FINISH: begin
            acc_q  <= '0;
            aad_q  <= '0;
            text_q <= '0;
            err_q  <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (go && is_finish) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // input word and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q <= w_d;
    end
    if (go && is_finish) begin
      tag_q  <= tag_d;
      lerr_q <= err_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign tag_high_o     = tag_q[BlockW-1:64];
  assign tag_low_o      = tag_q[63:0];
  assign length_error_o = lerr_q;

endmodule
